[hdl/are_pkg.sv]
// Package with the types, constants and commands of the adaptive range encoder.
`timescale 1ns / 1ps

package are_pkg;

  // Alphabet and model limits.
  localparam int unsigned AlphabetSize = 256;
  localparam int unsigned SymW = 8;
  localparam int unsigned CntW = 14;
  localparam int unsigned CumW = 15;
  localparam int unsigned TotalLimit = 16384;
  localparam int unsigned GrpBits = 4;
  localparam int unsigned NumGrp = AlphabetSize >> GrpBits;
  localparam int unsigned GrpW = SymW - GrpBits;

  // Coder constants.
  localparam int unsigned CodeW = 32;
  localparam logic [CodeW-1:0] FullRange = 32'hFFFF_FFFF;
  localparam logic [CodeW-1:0] BotBound = 32'h0001_0000;
  localparam int unsigned NormMax = 4;
  localparam int unsigned FlushBytes = 4;

  // Controller states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_GSCAN,
    S_CSCAN,
    S_DIVWAIT,
    S_NARROW,
    S_NORM,
    S_UPDATE,
    S_HRD,
    S_HWR,
    S_FLUSH,
    S_CLEAR
  } state_t;

  // Datapath operations.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_GSCAN,
    OP_CSCAN,
    OP_MUL,
    OP_NARROW,
    OP_NORM,
    OP_UPDATE,
    OP_HWR,
    OP_FLUSH,
    OP_CLEAR
  } op_t;

  typedef struct packed {
    op_t op;
  } cmd_t;

  typedef struct packed {
    logic gscan_done;
    logic cscan_done;
    logic div_done;
    logic norm_emit;
    logic halve_need;
    logic halve_done;
    logic flush_done;
    logic last;
    logic out_free;
  } status_t;

endpackage

[hdl/are_ifs.sv]
// Valid/ready channel interfaces for the symbol input and the code byte output.
`timescale 1ns / 1ps

interface are_in_if;
  logic                       valid;
  logic                       ready;
  logic [are_pkg::SymW-1:0]   symbol;
  logic                       end_of_block;
  modport source (output valid, output symbol, output end_of_block, input ready);
  modport sink (input valid, input symbol, input end_of_block, output ready);
endinterface

interface are_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       final_byte;
  logic       not_smaller;
  modport source (output valid, output code_byte, output final_byte, output not_smaller,
                  input ready);
  modport sink (input valid, input code_byte, input final_byte, input not_smaller,
                output ready);
endinterface

[hdl/are_div.sv]
// Bit-serial restoring divider: 32-bit range over the model total.
`timescale 1ns / 1ps

module are_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [are_pkg::CodeW-1:0]     dividend,
  input  logic [are_pkg::CumW-1:0]      divisor,
  output logic                          done,
  output logic [are_pkg::CodeW-1:0]     step
);

  logic [are_pkg::CodeW-1:0] q_r, q_nxt;
  logic [are_pkg::CumW-1:0]  rem_r, rem_nxt;
  logic [5:0]                cnt_r, cnt_nxt;
  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [are_pkg::CumW:0]    shifted;
  logic [are_pkg::CumW+1:0]  trial;

  // One quotient bit per cycle.
  always_comb begin
    shifted  = {rem_r, q_r[are_pkg::CodeW-1]};
    trial    = {1'b0, shifted} - {2'b00, divisor};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = 6'(are_pkg::CodeW);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (!trial[are_pkg::CumW+1]) begin
        rem_nxt = trial[are_pkg::CumW-1:0];
        q_nxt   = {q_r[are_pkg::CodeW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[are_pkg::CumW-1:0];
        q_nxt   = {q_r[are_pkg::CodeW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  // A zero quotient codes with a step of one.
  assign done = done_r;
  assign step = (q_r == '0) ? {{(are_pkg::CodeW-1){1'b0}}, 1'b1} : q_r;

endmodule

[hdl/are_ctrl.sv]
// Controller state machine that sequences each symbol through the datapath.
`timescale 1ns / 1ps

module are_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  are_pkg::status_t sts,
  output are_pkg::cmd_t    cmd
);

  are_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= are_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath command.
  always_comb begin
    state_nxt = state_r;
    cmd.op    = are_pkg::OP_NONE;
    in_ready  = 1'b0;
    unique case (state_r)
      are_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = are_pkg::OP_ACCEPT;
          state_nxt = are_pkg::S_GSCAN;
        end
      end
      are_pkg::S_GSCAN: begin
        cmd.op = are_pkg::OP_GSCAN;
        if (sts.gscan_done) begin
          state_nxt = are_pkg::S_CSCAN;
        end
      end
      are_pkg::S_CSCAN: begin
        cmd.op = are_pkg::OP_CSCAN;
        if (sts.cscan_done) begin
          state_nxt = are_pkg::S_DIVWAIT;
        end
      end
      are_pkg::S_DIVWAIT: begin
        if (sts.div_done) begin
          cmd.op    = are_pkg::OP_MUL;
          state_nxt = are_pkg::S_NARROW;
        end
      end
      are_pkg::S_NARROW: begin
        cmd.op    = are_pkg::OP_NARROW;
        state_nxt = are_pkg::S_NORM;
      end
      are_pkg::S_NORM: begin
        if (!sts.norm_emit) begin
          state_nxt = are_pkg::S_UPDATE;
        end else if (sts.out_free) begin
          cmd.op = are_pkg::OP_NORM;
        end
      end
      are_pkg::S_UPDATE: begin
        cmd.op = are_pkg::OP_UPDATE;
        priority if (sts.halve_need) begin
          state_nxt = are_pkg::S_HRD;
        end else if (sts.last) begin
          state_nxt = are_pkg::S_FLUSH;
        end else begin
          state_nxt = are_pkg::S_IDLE;
        end
      end
      are_pkg::S_HRD: begin
        state_nxt = are_pkg::S_HWR;
      end
      are_pkg::S_HWR: begin
        cmd.op = are_pkg::OP_HWR;
        priority if (!sts.halve_done) begin
          state_nxt = are_pkg::S_HRD;
        end else if (sts.last) begin
          state_nxt = are_pkg::S_FLUSH;
        end else begin
          state_nxt = are_pkg::S_IDLE;
        end
      end
      are_pkg::S_FLUSH: begin
        if (sts.out_free) begin
          cmd.op = are_pkg::OP_FLUSH;
          if (sts.flush_done) begin
            state_nxt = are_pkg::S_CLEAR;
          end
        end
      end
      are_pkg::S_CLEAR: begin
        cmd.op    = are_pkg::OP_CLEAR;
        state_nxt = are_pkg::S_IDLE;
      end
      default: begin
        state_nxt = are_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[hdl/are_dp.sv]
// Datapath: coder registers, adaptive count memory, group sums and output word.
`timescale 1ns / 1ps

module are_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  are_pkg::cmd_t             cmd,
  output are_pkg::status_t          sts,
  input  logic [are_pkg::SymW-1:0]  in_symbol,
  input  logic                      in_end_of_block,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                out_code_byte,
  output logic                      out_final_byte,
  output logic                      out_not_smaller
);

  localparam int unsigned Aw = are_pkg::SymW;
  localparam int unsigned Cw = are_pkg::CodeW;
  localparam logic [are_pkg::CumW-1:0] GrpInit = are_pkg::CumW'(1 << are_pkg::GrpBits);

  // Count memory with per-entry valid bits; an unwritten entry reads as one.
  logic [are_pkg::CntW-1:0] mem [are_pkg::AlphabetSize];
  logic [are_pkg::AlphabetSize-1:0] vld_r;
  logic [are_pkg::CntW-1:0] rd_r;
  logic                     rd_vld_r;
  logic [are_pkg::CntW-1:0] rd_val;
  logic                     wr_en;
  logic [Aw-1:0]            wr_addr;
  logic [are_pkg::CntW-1:0] wr_data;

  logic [are_pkg::CumW-1:0] grp_r [are_pkg::NumGrp];
  logic [are_pkg::CumW-1:0] total_r;
  logic [Cw-1:0]            low_r, range_r;
  logic [Aw-1:0]            sym_r, addr_r, rd_addr_r;
  logic [are_pkg::GrpW-1:0] gidx_r;
  logic                     last_r, ok_r;
  logic [are_pkg::CumW-1:0] cum_r;
  logic [are_pkg::CntW-1:0] cnt_r;
  logic [Cw-1:0]            plow_r, prange_r;
  logic [2:0]               ncnt_r;
  logic [1:0]               fcnt_r;
  logic [Cw-1:0]            seen_r, bytes_r;
  logic                     ov_r;
  logic [7:0]               ob_r;
  logic                     ofin_r, ons_r;

  logic                     div_done;
  logic [Cw-1:0]            step;
  logic [Cw-1:0]            low_sum, neg_low;
  logic                     settled;
  logic [Cw-1:0]            bytes_inc;
  logic [are_pkg::CntW-1:0] half_val;
  logic [are_pkg::GrpW-1:0] sym_grp;

  assign sym_grp = sym_r[Aw-1:are_pkg::GrpBits];

  are_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.op == are_pkg::OP_ACCEPT),
    .dividend (range_r),
    .divisor  (total_r),
    .done     (div_done),
    .step     (step)
  );

  // Registered memory read at the scan/sweep address.
  always_ff @(posedge clk) begin
    rd_r      <= mem[addr_r];
    rd_addr_r <= addr_r;
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == are_pkg::OP_CLEAR) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= vld_r[addr_r];
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
    end
  end

  assign rd_val   = rd_vld_r ? rd_r : are_pkg::CntW'(1);
  assign half_val = are_pkg::CntW'(({1'b0, rd_val} + 15'd1) >> 1);

  // Memory writes: increment at update, halved value during the sweep.
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sym_r;
    wr_data = cnt_r + are_pkg::CntW'(1);
    if (cmd.op == are_pkg::OP_UPDATE) begin
      wr_en = 1'b1;
    end else if (cmd.op == are_pkg::OP_HWR) begin
      wr_en   = 1'b1;
      wr_addr = addr_r;
      wr_data = half_val;
    end
  end

  // Normalization helpers.
  assign low_sum   = low_r + range_r;
  assign settled   = ((low_r ^ low_sum) >> 24) == '0;
  assign neg_low   = '0 - low_r;
  assign bytes_inc = (bytes_r == are_pkg::FullRange) ? bytes_r : bytes_r + 32'd1;

  // Status toward the controller.
  always_comb begin
    sts.gscan_done = (gidx_r == sym_grp);
    sts.cscan_done = ok_r && (rd_addr_r == sym_r);
    sts.div_done   = div_done;
    sts.norm_emit  = (ncnt_r < 3'(are_pkg::NormMax)) && (range_r != '0) &&
                     (settled || (range_r < are_pkg::BotBound));
    sts.halve_need = ({1'b0, total_r} + 16'd1) >= 16'(are_pkg::TotalLimit);
    sts.halve_done = (addr_r == Aw'(are_pkg::AlphabetSize - 1));
    sts.flush_done = (fcnt_r == 2'(are_pkg::FlushBytes - 1));
    sts.last       = last_r;
    sts.out_free   = !ov_r || out_ready;
  end

  // Coder, model and scan registers.
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.op == are_pkg::OP_CLEAR) begin
      low_r   <= '0;
      range_r <= are_pkg::FullRange;
      total_r <= are_pkg::CumW'(are_pkg::AlphabetSize);
      for (int i = 0; i < are_pkg::NumGrp; i++) begin
        grp_r[i] <= GrpInit;
      end
      seen_r  <= '0;
      bytes_r <= '0;
      ok_r    <= 1'b0;
      ncnt_r  <= '0;
      fcnt_r  <= '0;
    end else begin
      ok_r <= (cmd.op == are_pkg::OP_CSCAN);
      unique case (cmd.op)
        are_pkg::OP_ACCEPT: begin
          sym_r  <= in_symbol;
          last_r <= in_end_of_block;
          gidx_r <= '0;
          cum_r  <= '0;
          if (seen_r != are_pkg::FullRange) begin
            seen_r <= seen_r + 32'd1;
          end
        end
        are_pkg::OP_GSCAN: begin
          if (gidx_r == sym_grp) begin
            addr_r <= {sym_grp, {are_pkg::GrpBits{1'b0}}};
          end else begin
            cum_r  <= cum_r + grp_r[gidx_r];
            gidx_r <= gidx_r + are_pkg::GrpW'(1);
          end
        end
        are_pkg::OP_CSCAN: begin
          if (addr_r != sym_r) begin
            addr_r <= addr_r + Aw'(1);
          end
          if (ok_r) begin
            if (rd_addr_r == sym_r) begin
              cnt_r <= rd_val;
            end else begin
              cum_r <= cum_r + are_pkg::CumW'(rd_val);
            end
          end
        end
        are_pkg::OP_MUL: begin
          plow_r   <= Cw'(step * cum_r);
          prange_r <= Cw'(step * cnt_r);
        end
        are_pkg::OP_NARROW: begin
          low_r   <= low_r + plow_r;
          range_r <= prange_r;
          ncnt_r  <= '0;
        end
        are_pkg::OP_NORM: begin
          if (settled) begin
            range_r <= range_r << 8;
          end else begin
            range_r <= {8'h00, neg_low[15:0], 8'h00};
          end
          low_r   <= low_r << 8;
          ncnt_r  <= ncnt_r + 3'd1;
          bytes_r <= bytes_inc;
        end
        are_pkg::OP_UPDATE: begin
          if (sts.halve_need) begin
            for (int i = 0; i < are_pkg::NumGrp; i++) begin
              grp_r[i] <= '0;
            end
            total_r <= '0;
            addr_r  <= '0;
          end else begin
            grp_r[sym_grp] <= grp_r[sym_grp] + are_pkg::CumW'(1);
            total_r        <= total_r + are_pkg::CumW'(1);
          end
          fcnt_r <= '0;
        end
        are_pkg::OP_HWR: begin
          grp_r[addr_r[Aw-1:are_pkg::GrpBits]] <=
            grp_r[addr_r[Aw-1:are_pkg::GrpBits]] + are_pkg::CumW'(half_val);
          total_r <= total_r + are_pkg::CumW'(half_val);
          addr_r  <= addr_r + Aw'(1);
        end
        are_pkg::OP_FLUSH: begin
          low_r   <= low_r << 8;
          fcnt_r  <= fcnt_r + 2'd1;
          bytes_r <= bytes_inc;
        end
        default: begin
        end
      endcase
    end
  end

  // Output word register; it is loaded only when free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (cmd.op == are_pkg::OP_NORM || cmd.op == are_pkg::OP_FLUSH) begin
      ov_r <= 1'b1;
    end else if (out_ready) begin
      ov_r <= 1'b0;
    end
    if (cmd.op == are_pkg::OP_NORM) begin
      ob_r   <= low_r[Cw-1:Cw-8];
      ofin_r <= 1'b0;
      ons_r  <= 1'b0;
    end else if (cmd.op == are_pkg::OP_FLUSH) begin
      ob_r   <= low_r[Cw-1:Cw-8];
      ofin_r <= sts.flush_done;
      ons_r  <= sts.flush_done && (bytes_inc >= seen_r);
    end
  end

  assign out_valid       = ov_r;
  assign out_code_byte   = ob_r;
  assign out_final_byte  = ofin_r;
  assign out_not_smaller = ons_r;

endmodule

[hdl/adaptive_range_encoder.sv]
// Top level of the adaptive order-0 range encoder.
//
//   Channel  Dir  Payload                                   Accepted when
//   in_if    in   symbol[7:0], end_of_block                 valid && ready
//   out_if   out  code_byte[7:0], final_byte, not_smaller   valid && ready
//
// For each symbol, the serial divide of range by the model total runs beside
// the group-sum and count-memory scans, then come multiply, narrow, and the
// emission of 0 to 4 bytes.
// When the total reaches its limit, a halving sweep runs over the count memory;
// a last symbol adds four flush bytes and a model reset.
// Reset is synchronous and returns coder and model to their initial state.
// A stalled output word holds byte emission; input is taken only when idle.
`timescale 1ns / 1ps

module adaptive_range_encoder (
  input  logic       clk,
  input  logic       rst_n,
  are_in_if.sink     in_if,
  are_out_if.source  out_if
);

  are_pkg::cmd_t    cmd;
  are_pkg::status_t sts;

  are_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  are_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_symbol       (in_if.symbol),
    .in_end_of_block (in_if.end_of_block),
    .out_valid       (out_if.valid),
    .out_ready       (out_if.ready),
    .out_code_byte   (out_if.code_byte),
    .out_final_byte  (out_if.final_byte),
    .out_not_smaller (out_if.not_smaller)
  );

endmodule

[hdl/are_chk.sv]
// Port checker for the range encoder, bound to the top level.
`timescale 1ns / 1ps

module are_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] code_byte,
  input logic       final_byte,
  input logic       not_smaller
);

  // No word is shown right after reset.
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output word valid after reset");

  // A stalled word holds its byte.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(code_byte))
    else $error("stalled output word changed");

  // The size flag appears only on the final byte.
  a_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && not_smaller |-> final_byte)
    else $error("not_smaller outside the final byte");

  // After a symbol is taken, the input is not ready again at once.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready ##1 !in_ready)
    else $error("input taken again too soon");

endmodule

bind adaptive_range_encoder are_chk u_are_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .out_ready   (out_if.ready),
  .code_byte   (out_if.code_byte),
  .final_byte  (out_if.final_byte),
  .not_smaller (out_if.not_smaller)
);
